// File: design/quadratic_probe_hash_table_core_defines.svh
// assertion macros for the hash table core
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_DEFINES_SVH
// property that holds from a reset-qualified clock
`define QPH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked also during reset
`define QPH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: design/qph_pkg.sv
// shared types and constants of the hash table core
`timescale 1ns / 1ps
package qph_pkg;
  localparam int SLOT_COUNT = 1031;
  localparam int KEY_BYTES = 20;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int SUM_W = 13;
  localparam int KEY_W = 160;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [KEY_W-1:0] key;
    logic [SLOT_W-1:0] home;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] found_value;
    logic [10:0] slot_index;
  } rsp_t;
endpackage

// File: design/qph_front.sv
// front end: key normalisation and home slot computation
`timescale 1ns / 1ps
module qph_front import qph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [1:0] in_op,
  input  logic [63:0] in_key_bytes_low,
  input  logic [63:0] in_key_bytes_mid,
  input  logic [31:0] in_key_bytes_high,
  input  logic [31:0] in_entry_value,
  output logic cmd_valid,
  input  logic cmd_ready,
  output cmd_t cmd
);
  localparam int BYTE_CNT_W = $clog2(KEY_W/8 + 1);
  typedef enum logic [1:0] {F_IDLE, F_SUM, F_MOD, F_OUT} fstate_t;
  fstate_t state_r;
  logic [KEY_W-1:0] raw_r, key_r;
  logic [1:0] op_r;
  logic [31:0] val_r;
  logic [SUM_W-1:0] sum_r;
  logic [BYTE_CNT_W-1:0] idx_r;
  logic ended_r;
  logic [SUM_W-1:0] sum_sub;

  assign in_full = (state_r != F_IDLE);
  assign cmd_valid = (state_r == F_OUT);
  assign sum_sub = sum_r - SUM_W'(SLOT_COUNT);

  // four bytes a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: if (in_push) begin
          raw_r <= {in_key_bytes_high, in_key_bytes_mid, in_key_bytes_low};
          op_r <= in_op;
          val_r <= in_entry_value;
          key_r <= '0;
          sum_r <= '0;
          idx_r <= '0;
          ended_r <= 1'b0;
          state_r <= F_SUM;
        end
        F_SUM: begin : sum_blk
          logic e;
          logic [SUM_W-1:0] s;
          logic [7:0] bb;
          logic [KEY_W-1:0] k;
          e = ended_r;
          s = sum_r;
          k = key_r;
          for (int j = 0; j < 4; j++) begin
            bb = raw_r[8*(int'(idx_r)+j) +: 8];
            if ((int'(idx_r) + j) >= KEY_BYTES || bb == 8'd0) e = 1'b1;
            if (!e) begin
              s = s + SUM_W'(bb);
              k[8*(int'(idx_r)+j) +: 8] = bb;
            end
          end
          ended_r <= e;
          sum_r <= s;
          key_r <= k;
          idx_r <= idx_r + BYTE_CNT_W'(4);
          if (int'(idx_r) + 4 >= KEY_W/8) state_r <= F_MOD;
        end
        F_MOD: begin
          if (sum_r >= SUM_W'(SLOT_COUNT)) sum_r <= sum_sub;
          else state_r <= F_OUT;
        end
        F_OUT: if (cmd_ready) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign cmd.op = op_r;
  assign cmd.key = key_r;
  assign cmd.home = sum_r[SLOT_W-1:0];
  assign cmd.value = val_r;
endmodule

// File: design/qph_cmd_fifo.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module qph_cmd_fifo import qph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wr_data;
        wp_r <= ~wp_r;
      end
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

// File: design/qph_back.sv
// back end: clearing pass, probe walk over the slot memories, result register
`timescale 1ns / 1ps
`include "quadratic_probe_hash_table_core_defines.svh"
module qph_back import qph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic out_empty,
  input  logic out_pop,
  output rsp_t rsp
);
  localparam int CNT_W = $clog2(SLOT_COUNT + 2);
  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_EVAL, B_DONE} bstate_t;
  bstate_t state_r;
  logic [1:0] mark_mem [SLOT_COUNT];
  logic [KEY_W-1:0] key_mem [SLOT_COUNT];
  logic [31:0] val_mem [SLOT_COUNT];
  logic [1:0] mark_q;
  logic [KEY_W-1:0] key_q;
  logic [31:0] val_q;
  cmd_t c_r;
  logic [SLOT_W-1:0] slot_r, clr_r;
  logic [SLOT_W-1:0] step_r;
  logic [CNT_W-1:0] i_r;
  logic out_valid_r;
  rsp_t rsp_r;
  rsp_t res_r;
  logic [SLOT_W:0] s_add, o_add;
  logic [SLOT_W-1:0] slot_n, step_n;
  logic last;

  assign cmd_ready = (state_r == B_IDLE);
  assign out_empty = !out_valid_r;
  assign rsp = rsp_r;
  // next probe: slot += 2i+1, step holds (2i+1) mod size
  assign s_add = {1'b0, slot_r} + {1'b0, step_r};
  assign slot_n = (s_add >= (SLOT_W+1)'(SLOT_COUNT)) ?
                  SLOT_W'(s_add - (SLOT_W+1)'(SLOT_COUNT)) : s_add[SLOT_W-1:0];
  assign o_add = {1'b0, step_r} + (SLOT_W+1)'(2);
  assign step_n = (o_add >= (SLOT_W+1)'(SLOT_COUNT)) ?
                  SLOT_W'(o_add - (SLOT_W+1)'(SLOT_COUNT)) : o_add[SLOT_W-1:0];
  assign last = (c_r.op == OP_INSERT) ? (i_r == CNT_W'(SLOT_COUNT - 1))
                                      : (i_r == CNT_W'(SLOT_COUNT));

  always_ff @(posedge clk) begin
    mark_q <= mark_mem[slot_r];
    key_q <= key_mem[slot_r];
    val_q <= val_mem[slot_r];
    if (state_r == B_CLEAR) mark_mem[clr_r] <= MARK_EMPTY;
    if (state_r == B_EVAL) begin
      if (c_r.op == OP_INSERT && mark_q != MARK_USED) begin
        mark_mem[slot_r] <= MARK_USED;
        key_mem[slot_r] <= c_r.key;
        val_mem[slot_r] <= c_r.value;
      end else if (c_r.op == OP_DELETE && mark_q == MARK_USED && key_q == c_r.key) begin
        mark_mem[slot_r] <= MARK_TOMB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_DONE && (!out_valid_r || out_pop)) out_valid_r <= 1'b1;
      else if (out_pop && out_valid_r) out_valid_r <= 1'b0;
      unique case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + SLOT_W'(1);
          if (clr_r == SLOT_W'(SLOT_COUNT - 1)) state_r <= B_IDLE;
        end
        B_IDLE: if (cmd_valid) begin
          c_r <= cmd;
          slot_r <= cmd.home;
          step_r <= SLOT_W'(1);
          i_r <= '0;
          if (cmd.op == OP_SEARCH || cmd.op == OP_INSERT || cmd.op == OP_DELETE)
            state_r <= B_READ;
          else begin
            res_r <= '{status: ST_MISS, found_value: '0, slot_index: '0};
            state_r <= B_DONE;
          end
        end
        B_READ: state_r <= B_EVAL;
        B_EVAL: begin
          priority if (c_r.op == OP_INSERT && mark_q != MARK_USED) begin
            res_r <= '{status: ST_OK, found_value: '0, slot_index: 11'(slot_r)};
            state_r <= B_DONE;
          end else if (c_r.op != OP_INSERT && mark_q == MARK_EMPTY) begin
            res_r <= '{status: ST_MISS, found_value: '0, slot_index: '0};
            state_r <= B_DONE;
          end else if (c_r.op != OP_INSERT && mark_q == MARK_USED && key_q == c_r.key) begin
            res_r <= '{status: ST_OK, found_value: val_q, slot_index: 11'(slot_r)};
            state_r <= B_DONE;
          end else if (last) begin
            res_r <= '{status: (c_r.op == OP_INSERT) ? ST_FULL : ST_MISS,
                       found_value: '0, slot_index: '0};
            state_r <= B_DONE;
          end else begin
            slot_r <= slot_n;
            step_r <= step_n;
            i_r <= i_r + CNT_W'(1);
            state_r <= B_READ;
          end
        end
        B_DONE: if (!out_valid_r || out_pop) begin
          rsp_r <= res_r;
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `QPH_ASSERT(a_no_accept_clear, clk, rst_n, (state_r == B_CLEAR) |-> !cmd_ready, "cmd during clear")
  `QPH_ASSERT(a_slot_range, clk, rst_n, (state_r == B_EVAL) |-> (slot_r < SLOT_W'(SLOT_COUNT)), "slot range")
  `QPH_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && !out_pop) |=> (out_valid_r && $stable(rsp_r)), "result dropped")
  `QPH_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty, "not empty after reset")
endmodule

// File: design/quadratic_probe_hash_table_core.sv
// top level of the quadratic probe hash table core
// Usage: words are pushed on the in_ queue (push while full is low) and
// results popped from the out_ queue (pop while empty is low), one result
// per word, in order. Op 0 searches, 1 inserts, 2 deletes a 20-byte key.
// The front normalises the key and sums its bytes, four a cycle, then
// reduces the sum by repeated subtraction; it takes a new word only after
// handing the last one over. A two-word queue parts it from the back,
// which walks the probe sequence one probe at a time (registered memory
// read, then compare and write back); with short chains the front sets
// the pace. After reset a clearing pass sets all SLOT_COUNT (1031) slot
// marks to empty; words are queued in the front meanwhile but not executed.
// When the receiver stalls the finished result is held in the output
// register; the back waits with its next result and the front and queue
// keep accepting words until they fill.
`timescale 1ns / 1ps
module quadratic_probe_hash_table_core import qph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  logic [1:0] in_op,
  input  logic [63:0] in_key_bytes_low,
  input  logic [63:0] in_key_bytes_mid,
  input  logic [31:0] in_key_bytes_high,
  input  logic [31:0] in_entry_value,
  output logic empty,
  input  logic pop,
  output logic [1:0] out_status,
  output logic [31:0] out_found_value,
  output logic [10:0] out_slot_index
);
  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;
  rsp_t rsp;

  qph_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_op, .in_key_bytes_low,
    .in_key_bytes_mid, .in_key_bytes_high, .in_entry_value,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );
  qph_cmd_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );
  qph_back u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_empty(empty), .out_pop(pop), .rsp
  );
  assign out_status = rsp.status;
  assign out_found_value = rsp.found_value;
  assign out_slot_index = rsp.slot_index;
endmodule

// File: sim/quadratic_probe_hash_table_core_test.sv
// self-checking testbench for the quadratic probe hash table core
`timescale 1ns / 1ps
module quadratic_probe_hash_table_core_test;
  import qph_pkg::*;

  typedef struct {
    logic [1:0] op;
    logic [159:0] key;
    logic [31:0] value;
    bit drain;
  } word_t;

  typedef struct {
    logic [1:0] status;
    logic [31:0] found_value;
    logic [10:0] slot_index;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] in_op = '0;
  logic [63:0] in_key_bytes_low = '0;
  logic [63:0] in_key_bytes_mid = '0;
  logic [31:0] in_key_bytes_high = '0;
  logic [31:0] in_entry_value = '0;
  logic full, empty;
  logic [1:0] out_status;
  logic [31:0] out_found_value;
  logic [10:0] out_slot_index;

  word_t pending_q[$];
  answer_t answer_q[$];
  logic [1:0] slot_state[SLOT_COUNT];
  logic [159:0] slot_key[SLOT_COUNT];
  logic [31:0] slot_value[SLOT_COUNT];
  int mismatches = 0;
  int cycles = 0;
  int rx_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic [159:0] pool[24];
  int pool_len[24];

  quadratic_probe_hash_table_core u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_op(in_op), .in_key_bytes_low(in_key_bytes_low),
    .in_key_bytes_mid(in_key_bytes_mid), .in_key_bytes_high(in_key_bytes_high),
    .in_entry_value(in_entry_value), .empty(empty), .pop(pop),
    .out_status(out_status), .out_found_value(out_found_value),
    .out_slot_index(out_slot_index)
  );

  always #5 clk = ~clk;

  // table model: one answer per word, state updated in place
  function automatic answer_t lookup_and_update(word_t w);
    answer_t a;
    logic [159:0] k;
    int sum, home, s;
    bit ended;
    k = w.key;
    sum = 0;
    ended = 0;
    for (int n = 0; n < 20; n++) begin
      if (n >= KEY_BYTES || k[8*n +: 8] == 8'd0) ended = 1;
      if (ended) k[8*n +: 8] = 8'd0;
      else sum += k[8*n +: 8];
    end
    home = sum % SLOT_COUNT;
    a.status = ST_MISS;
    a.found_value = '0;
    a.slot_index = '0;
    if (w.op == OP_SEARCH || w.op == OP_DELETE) begin
      for (int i = 0; i <= SLOT_COUNT; i++) begin
        s = (home + i * i) % SLOT_COUNT;
        if (slot_state[s] == MARK_EMPTY) break;
        if (slot_state[s] == MARK_USED && slot_key[s] == k) begin
          a.status = ST_OK;
          a.found_value = slot_value[s];
          a.slot_index = 11'(s);
          if (w.op == OP_DELETE) slot_state[s] = MARK_TOMB;
          break;
        end
      end
    end else if (w.op == OP_INSERT) begin
      a.status = ST_FULL;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        s = (home + i * i) % SLOT_COUNT;
        if (slot_state[s] != MARK_USED) begin
          slot_state[s] = MARK_USED;
          slot_key[s] = k;
          slot_value[s] = w.value;
          a.status = ST_OK;
          a.slot_index = 11'(s);
          break;
        end
      end
    end
    return a;
  endfunction

  task automatic queue_word(logic [1:0] op, logic [159:0] key, logic [31:0] value,
                            bit drain = 0);
    word_t w;
    w.op = op;
    w.key = key;
    w.value = value;
    w.drain = drain;
    pending_q.push_back(w);
  endtask

  // pool key with fresh junk after the terminator
  function automatic logic [159:0] pool_key(int idx);
    logic [159:0] k;
    k = pool[idx];
    for (int n = pool_len[idx] + 1; n < 20; n++) k[8*n +: 8] = 8'($urandom);
    return k;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        answer_q.push_back(lookup_and_update(pending_q[0]));
        void'(pending_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        push <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && (push || answer_q.size() != 0))) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_op <= pending_q[0].op;
        in_key_bytes_low <= pending_q[0].key[63:0];
        in_key_bytes_mid <= pending_q[0].key[127:64];
        in_key_bytes_high <= pending_q[0].key[159:128];
        in_entry_value <= pending_q[0].value;
        if (push && !full) begin
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ((cycles / 2000) % 3 == 0) ? 0 : $urandom_range(0, 12);
          end
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rst_n && pop && !empty) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: status %0d value %h slot %0d",
                   out_status, out_found_value, out_slot_index);
      end else begin
        if (out_status !== answer_q[0].status ||
            out_found_value !== answer_q[0].found_value ||
            out_slot_index !== answer_q[0].slot_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %h %0d, got %0d %h %0d",
                     answer_q[0].status, answer_q[0].found_value, answer_q[0].slot_index,
                     out_status, out_found_value, out_slot_index);
        end
        void'(answer_q.pop_front());
      end
    end
    if (rx_cycles >= 1500 && rx_cycles < 1900) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else if ((rx_cycles / 1000) % 2 == 1 && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(1, 10);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 2 * SLOT_COUNT * 2000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [159:0] k;
    int idx, r, len;
    for (int s = 0; s < SLOT_COUNT; s++) slot_state[s] = MARK_EMPTY;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_word(OP_SEARCH, '0, 32'h0);
    queue_word(OP_INSERT, '0, 32'hFFFF_FFFF);
    queue_word(OP_SEARCH, {152'h0, 8'h00} | {80'h1234, 80'h0}, 32'h5);
    queue_word(OP_INSERT, {160{1'b1}}, 32'h0);
    queue_word(OP_SEARCH, {160{1'b1}}, 32'h0);
    k = '0;
    k[23:0] = 24'h636261;
    queue_word(OP_INSERT, k | {96'hDEAD_BEEF, 64'h0}, 32'h1111_1111);
    queue_word(OP_SEARCH, k | {128'h55, 32'h0}, 32'h0);
    queue_word(OP_INSERT, k, 32'h2222_2222);
    queue_word(OP_SEARCH, k, 32'h0);
    queue_word(OP_UNUSED, k, 32'hFFFF_FFFF);
    queue_word(OP_UNUSED, {160{1'b1}}, 32'h0);
    queue_word(OP_DELETE, k, 32'h0);
    queue_word(OP_SEARCH, k, 32'h0);
    queue_word(OP_DELETE, k, 32'h0);
    queue_word(OP_DELETE, k, 32'h0);
    queue_word(OP_DELETE, k, 32'h0);
    queue_word(OP_INSERT, k, 32'h3333_3333);
    queue_word(OP_SEARCH, k, 32'h0);
    queue_word(OP_DELETE, '0, 32'h0);
    queue_word(OP_SEARCH, '0, 32'h0);

    // random
    for (int p = 0; p < 24; p++) begin
      len = (p == 0) ? 20 : $urandom_range(1, 19);
      pool_len[p] = len;
      pool[p] = '0;
      for (int n = 0; n < len; n++) pool[p][8*n +: 8] = 8'($urandom_range(1, 255));
    end
    for (int j = 0; j < 360; j++) begin
      idx = $urandom_range(0, 23);
      k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom, $urandom, $urandom, $urandom}
                                        : pool_key(idx);
      r = $urandom_range(0, 99);
      queue_word(r < 40 ? OP_INSERT : r < 75 ? OP_SEARCH : r < 95 ? OP_DELETE : OP_UNUSED,
                 k, $urandom, j == 200);
    end

    // one long probe path
    k = pool_key(1);
    for (int j = 0; j < 20; j++) queue_word(OP_INSERT, k, $urandom, j == 0);
    queue_word(OP_SEARCH, k, 32'h0);
    queue_word(OP_DELETE, pool_key(1), 32'h0);
    queue_word(OP_SEARCH, {$urandom, $urandom, $urandom, $urandom, $urandom}, 32'h0);
    queue_word(OP_INSERT, k, 32'hA5A5_A5A5);

    while (pending_q.size() != 0 || answer_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
